// ----- rtl/bsve_pkg.sv -----
// Shared types, register indexes and color ramp tables of the billboard vertex expander.
`default_nettype none

package bsve_pkg;

  typedef logic signed [15:0] axis_t;
  typedef logic [1:0] seg_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z    = 3'd5;

  localparam axis_t AXIS_ONE  = 16'sd16384;
  localparam axis_t AXIS_ZERO = 16'sd0;

  // 1.0 in Q1.15 for heat and opacity
  localparam logic [15:0] FRAC_ONE = 16'd32768;

  // ramp segments: smoke, smoke to red, red to orange, orange to white
  localparam seg_t SEG_SMOKE  = 2'd0;
  localparam seg_t SEG_RED    = 2'd1;
  localparam seg_t SEG_ORANGE = 2'd2;
  localparam seg_t SEG_WHITE  = 2'd3;

  // segment start as 100 * heat, i.e. start_hundredths * 32768
  localparam logic [21:0] SEG_START [4] = '{
    22'd0, 22'(25 * 32768), 22'(50 * 32768), 22'(85 * 32768)
  };

  // 255 * c0 * width: channel value at segment start, scaled by the divisor
  localparam logic signed [20:0] RAMP_BASE [4][3] = '{
    '{21'sd159375, 21'sd159375, 21'sd178500},
    '{21'sd382500, 21'sd95625,  21'sd31875},
    '{21'sd892500, 21'sd357000, 21'sd44625},
    '{21'sd382500, 21'sd325125, 21'sd153000}
  };

  // 255 * (c1 - c0): channel slope against 100 * heat, in units of 2^-15
  localparam logic signed [15:0] RAMP_SLOPE [4][3] = '{
    '{16'sd8925,  -16'sd2550, -16'sd5865},
    '{16'sd10200, 16'sd6375,  16'sd0},
    '{16'sd0,     16'sd11475, 16'sd8925},
    '{16'sd0,     16'sd3825,  16'sd14025}
  };

  // divisor 100 * width replaced by ceil(2^32 / divisor); exact for dividends below 2^20
  localparam int RECIP_SHIFT = 32;
  localparam logic [21:0] SEG_RECIP [4] = '{
    22'(((64'd1 << RECIP_SHIFT) + 64'd2500 - 64'd1) / 64'd2500),
    22'(((64'd1 << RECIP_SHIFT) + 64'd2500 - 64'd1) / 64'd2500),
    22'(((64'd1 << RECIP_SHIFT) + 64'd3500 - 64'd1) / 64'd3500),
    22'(((64'd1 << RECIP_SHIFT) + 64'd1500 - 64'd1) / 64'd1500)
  };

  localparam logic [2:0] LAST_VTX = 3'd5;

  // corner of each vertex slot: bit 0 set for +right, bit 1 set for +up
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/billboard_sprite_vertex_expander_top.sv -----
// Billboard sprite vertex expander: particle in, six camera-facing quad vertices out.
`default_nettype none

// A particle request is taken on a clock edge with start high and busy low. It
// produces six vertices (triangles 0,1,2 and 2,1,3) back to back, one per cycle,
// each marked by result_valid for one cycle; the receiver cannot stall them.
// The request passes stages 1, 2 and 3 and the emit stage before its first
// vertex is registered on the outputs. A new particle can be taken while earlier
// ones are still in flight; up to three more particles queue in the pipeline while
// one is emitted, and busy rises once that queue is full. The configuration port is
// always ready; write the camera vectors only while no particle is in flight.
module billboard_sprite_vertex_expander_top
  import bsve_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    center_x,
  input  logic signed [31:0]    center_y,
  input  logic signed [31:0]    center_z,
  input  logic [30:0]           sprite_size,
  input  logic [15:0]           heat,
  input  logic [15:0]           opacity,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  result_valid,
  output logic signed [31:0]    vertex_x,
  output logic signed [31:0]    vertex_y,
  output logic signed [31:0]    vertex_z,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic [7:0]            alpha_byte,
  output logic                  tex_u,
  output logic                  tex_v,
  output logic                  last_vertex
);

  // camera vectors
  axis_t right [3];
  axis_t up [3];

  // handshake between stages
  logic accept;
  logic s1_valid, s2_valid, s3_valid, e_valid;
  logic s2_load, s3_load, e_load;

  // stage 1: captured request
  logic signed [31:0] s1_ctr [3];
  logic [30:0]        s1_size;
  logic [15:0]        s1_heat;
  logic [15:0]        s1_opac;

  // stage 1 -> 2 logic
  logic [15:0]        heat_c;
  logic [15:0]        opac_c;
  logic [21:0]        heat_x100;
  seg_t               seg;
  logic signed [22:0] seg_pos;
  logic signed [38:0] ramp_prod [3];
  logic [23:0]        alpha_prod;
  logic signed [46:0] r_prod [3];
  logic signed [46:0] u_prod [3];

  // stage 2
  logic signed [31:0] s2_ctr [3];
  logic signed [46:0] s2_pr [3];
  logic signed [46:0] s2_pu [3];
  logic signed [38:0] s2_rprod [3];
  seg_t               s2_seg;
  logic [7:0]         s2_alpha;

  // stage 2 -> 3 logic
  logic signed [24:0] y_wide [3];
  logic [19:0]        y_div [3];
  logic [41:0]        col_prod [3];

  // stage 3
  logic signed [31:0] s3_ctr [3];
  logic signed [46:0] s3_pr [3];
  logic signed [46:0] s3_pu [3];
  logic [41:0]        s3_cprod [3];
  logic [7:0]         s3_alpha;
  logic [7:0]         col_byte [3];

  // emit stage
  logic signed [31:0] e_ctr [3];
  logic signed [46:0] e_pr [3];
  logic signed [46:0] e_pu [3];
  logic [7:0]         e_col [3];
  logic [7:0]         e_alpha;
  logic [2:0]         e_k;
  logic [1:0]         corner;
  logic signed [48:0] vsum [3];
  logic signed [33:0] vfloor [3];
  logic signed [31:0] vsat [3];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right[0] <= AXIS_ONE;
      right[1] <= AXIS_ZERO;
      right[2] <= AXIS_ZERO;
      up[0]    <= AXIS_ZERO;
      up[1]    <= AXIS_ONE;
      up[2]    <= AXIS_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RIGHT_X: right[0] <= cfg_data;
        CFG_RIGHT_Y: right[1] <= cfg_data;
        CFG_RIGHT_Z: right[2] <= cfg_data;
        CFG_UP_X:    up[0]    <= cfg_data;
        CFG_UP_Y:    up[1]    <= cfg_data;
        CFG_UP_Z:    up[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- handshake
  assign e_load  = s3_valid && (!e_valid || e_k == LAST_VTX);
  assign s3_load = s2_valid && (!s3_valid || e_load);
  assign s2_load = s1_valid && (!s2_valid || s3_load);
  assign busy    = s1_valid && !s2_load;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      e_valid  <= 1'b0;
      e_k      <= 3'd0;
    end else begin
      s1_valid <= accept || (s1_valid && !s2_load);
      s2_valid <= s2_load || (s2_valid && !s3_load);
      s3_valid <= s3_load || (s3_valid && !e_load);
      if (e_load) begin
        e_valid <= 1'b1;
        e_k     <= 3'd0;
      end else if (e_valid) begin
        // drop out after the sixth vertex
        e_valid <= (e_k != LAST_VTX);
        e_k     <= e_k + 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctr[0] <= center_x;
      s1_ctr[1] <= center_y;
      s1_ctr[2] <= center_z;
      s1_size   <= sprite_size;
      s1_heat   <= heat;
      s1_opac   <= opacity;
    end
  end

  // ------------------------------------------------- ramp select, products
  always_comb begin
    heat_c    = (s1_heat > FRAC_ONE) ? FRAC_ONE : s1_heat;
    opac_c    = (s1_opac > FRAC_ONE) ? FRAC_ONE : s1_opac;
    heat_x100 = 22'(heat_c) * 22'd100;
    if (heat_x100 > SEG_START[SEG_WHITE]) begin
      seg = SEG_WHITE;
    end else if (heat_x100 > SEG_START[SEG_ORANGE]) begin
      seg = SEG_ORANGE;
    end else if (heat_x100 > SEG_START[SEG_RED]) begin
      seg = SEG_RED;
    end else begin
      seg = SEG_SMOKE;
    end
    seg_pos    = $signed({1'b0, heat_x100}) - $signed({1'b0, SEG_START[seg]});
    alpha_prod = 24'(opac_c) * 24'd255;
    for (int a = 0; a < 3; a++) begin
      ramp_prod[a] = 39'(RAMP_SLOPE[seg][a]) * 39'(seg_pos);
      r_prod[a]    = 47'(right[a]) * 47'($signed({1'b0, s1_size}));
      u_prod[a]    = 47'(up[a]) * 47'($signed({1'b0, s1_size}));
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      for (int a = 0; a < 3; a++) begin
        s2_ctr[a]   <= s1_ctr[a];
        s2_pr[a]    <= r_prod[a];
        s2_pu[a]    <= u_prod[a];
        s2_rprod[a] <= ramp_prod[a];
      end
      s2_seg   <= seg;
      s2_alpha <= alpha_prod[22:15];
    end
  end

  // --------------------------------------- channel value, reciprocal divide
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y_wide[c] = 25'(RAMP_BASE[s2_seg][c]) + 25'(s2_rprod[c] >>> 15);
      if (y_wide[c][24]) begin
        y_div[c] = '0;
      end else if (|y_wide[c][23:20]) begin
        y_div[c] = '1;
      end else begin
        y_div[c] = y_wide[c][19:0];
      end
      col_prod[c] = 42'(y_div[c]) * 42'(SEG_RECIP[s2_seg]);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      for (int a = 0; a < 3; a++) begin
        s3_ctr[a]   <= s2_ctr[a];
        s3_pr[a]    <= s2_pr[a];
        s3_pu[a]    <= s2_pu[a];
        s3_cprod[a] <= col_prod[a];
      end
      s3_alpha <= s2_alpha;
    end
  end

  // ------------------------------------------------------------- emit stage
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_byte[c] = (s3_cprod[c][41:32] > 10'd255) ? 8'd255 : s3_cprod[c][39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      for (int a = 0; a < 3; a++) begin
        e_ctr[a] <= s3_ctr[a];
        e_pr[a]  <= s3_pr[a];
        e_pu[a]  <= s3_pu[a];
        e_col[a] <= col_byte[a];
      end
      e_alpha <= s3_alpha;
    end
  end

  always_comb begin
    corner = corner_of(e_k);
    for (int a = 0; a < 3; a++) begin
      vsum[a] = $signed({{2{e_ctr[a][31]}}, e_ctr[a], 15'd0})
              + (corner[0] ? 49'(e_pr[a]) : -49'(e_pr[a]))
              + (corner[1] ? 49'(e_pu[a]) : -49'(e_pu[a]));
      // floor back to Q16.16, then saturate
      vfloor[a] = vsum[a][48:15];
      if (vfloor[a][33:31] == 3'b000 || vfloor[a][33:31] == 3'b111) begin
        vsat[a] = vfloor[a][31:0];
      end else if (vfloor[a][33]) begin
        vsat[a] = 32'sh8000_0000;
      end else begin
        vsat[a] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    vertex_x    <= vsat[0];
    vertex_y    <= vsat[1];
    vertex_z    <= vsat[2];
    red         <= e_col[0];
    green       <= e_col[1];
    blue        <= e_col[2];
    alpha_byte  <= e_alpha;
    tex_u       <= corner[0];
    tex_v       <= !corner[1];
    last_vertex <= (e_k == LAST_VTX);
  end

  // ------------------------------------------------------------ assertions
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> s1_valid)
    else $error("accepted request not held in input stage");

  a_vertex_count: assert property (@(posedge clk) disable iff (rst)
    (e_valid && e_k != LAST_VTX) |=> (e_valid && e_k == $past(e_k) + 3'd1))
    else $error("vertex counter skipped or stopped mid sprite");

  a_six_in_a_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_vertex) |=> result_valid)
    else $error("gap inside a sprite's vertex run");

  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_vertex) |-> (tex_u && !tex_v))
    else $error("last vertex is not the top right corner");

endmodule

`default_nettype wire
